### sv/crc32cm_pkg.sv
// Shared types and constants for the CRC-32 piece merger.
// No dependencies; every other file of the block but the RAM uses this package.
`timescale 1ns / 1ps
`default_nettype none

package crc32cm_pkg;

  localparam int CRC_W      = 32;
  localparam int LEN_W      = 63;
  // Bits of the GF(2) multiply handled per clock by the shared multiply unit.
  localparam int STEP_BITS  = 8;
  localparam int MUL_CYCLES = CRC_W / STEP_BITS;
  localparam int CNT_W      = $clog2(MUL_CYCLES);

  localparam logic [CRC_W-1:0] ALL_ONES   = 32'hffff_ffff;
  localparam logic [CRC_W-1:0] UNIT_POLY  = 32'h8000_0000;
  localparam logic [CRC_W-1:0] POLY_RESET = 32'hedb8_8320;
  // x^8 in reflected form, the first entry of the power table.
  localparam logic [CRC_W-1:0] X8_POWER   = UNIT_POLY >> 8;

  typedef enum logic [2:0] {
    ST_BUILD_INIT,
    ST_BUILD_WRITE,
    ST_BUILD_MUL,
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_MUL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic build_init;
    logic load_square;
    logic load_item;
    logic mul_step;
    logic mul_commit;
    logic finish;
    logic tbl_write;
  } cmd_t;

  typedef struct packed {
    logic len_bit;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

### sv/crc32cm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module crc32cm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### sv/crc32cm_ctrl.sv
// Sequencer for the CRC-32 piece merger: table build, length scan and multiply steps.
// Depends on crc32cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc32cm_ctrl #(
  parameter int MAX_POWER = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           cfg_write_enable,
  input  crc32cm_pkg::stat_t             stat,
  output crc32cm_pkg::cmd_t              cmd,
  output logic [$clog2(MAX_POWER+1)-1:0] tbl_idx,
  output logic                           in_stall
);

  import crc32cm_pkg::*;

  localparam int IDX_W    = $clog2(MAX_POWER + 1);
  localparam int LEN_BITS = (MAX_POWER + 1 < LEN_W) ? MAX_POWER + 1 : LEN_W;
  localparam logic [IDX_W-1:0] TOP_K  = IDX_W'(LEN_BITS - 1);
  localparam logic [IDX_W-1:0] LAST_K = IDX_W'(MAX_POWER);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MUL_CYCLES - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] k, k_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BUILD_INIT;
      k     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;

    case (state)
      ST_BUILD_INIT: begin
        cmd.build_init = 1'b1;
        k_next         = '0;
        state_next     = ST_BUILD_WRITE;
      end
      ST_BUILD_WRITE: begin
        cmd.tbl_write = 1'b1;
        if (k == LAST_K) begin
          state_next = ST_IDLE;
        end else begin
          cmd.load_square = 1'b1;
          k_next          = k + 1'b1;
          cnt_next        = '0;
          state_next      = ST_BUILD_MUL;
        end
      end
      ST_BUILD_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LAST_CNT) begin
          cmd.mul_commit = 1'b1;
          state_next     = ST_BUILD_WRITE;
        end
      end
      ST_IDLE: begin
        in_stall = cfg_write_enable;
        if (in_valid && !cfg_write_enable) begin
          cmd.capture = 1'b1;
          k_next      = TOP_K;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.len_bit) begin
          state_next = ST_LOAD;
        end else if (k == '0) begin
          state_next = ST_FINISH;
        end else begin
          k_next = k - 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.load_item = 1'b1;
        cnt_next      = '0;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LAST_CNT) begin
          cmd.mul_commit = 1'b1;
          if (k == '0) begin
            state_next = ST_FINISH;
          end else begin
            k_next     = k - 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_BUILD_INIT;
      end
    endcase

    // A new polynomial always restarts the table build.
    if (cfg_write_enable) begin
      state_next = ST_BUILD_INIT;
    end
  end

  assign tbl_idx = k;

endmodule

`default_nettype wire

### sv/crc32cm_datapath.sv
// Datapath of the CRC-32 piece merger: operand registers, two-lane GF(2) multiply unit,
// merged register and output register. Depends on crc32cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc32cm_datapath #(
  parameter int MAX_POWER = 63
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  crc32cm_pkg::cmd_t                    cmd,
  input  logic [$clog2(MAX_POWER+1)-1:0]       tbl_idx,
  input  logic [crc32cm_pkg::CRC_W-1:0]        tbl_rdata,
  input  logic                                 cfg_write_enable,
  input  logic [crc32cm_pkg::CRC_W-1:0]        cfg_write_data,
  input  logic                                 restart,
  input  logic [crc32cm_pkg::LEN_W-1:0]        child_length,
  input  logic [crc32cm_pkg::CRC_W-1:0]        child_crc,
  input  logic                                 child_is_full,
  input  logic                                 out_stall,
  output crc32cm_pkg::stat_t                   stat,
  output logic [crc32cm_pkg::CRC_W-1:0]        tbl_wdata,
  output logic                                 out_valid,
  output logic [crc32cm_pkg::CRC_W-1:0]        merged_crc
);

  import crc32cm_pkg::*;

  localparam int LEN_BITS = (MAX_POWER + 1 < LEN_W) ? MAX_POWER + 1 : LEN_W;

  logic [CRC_W-1:0]    poly;
  logic [CRC_W-1:0]    merged;
  logic [LEN_BITS-1:0] len;
  logic [CRC_W-1:0]    piece;
  logic                full;
  logic [CRC_W-1:0]    v0, v1;
  logic [CRC_W-1:0]    ma0, ma1, mb, acc0, acc1;
  logic [CRC_W-1:0]    s_a0, s_a1, s_b, s_c0, s_c1;
  logic [CRC_W-1:0]    result;

  // Several bits of the multiply per clock; both lanes share the reduced b chain.
  always_comb begin
    s_a0 = ma0;
    s_a1 = ma1;
    s_b  = mb;
    s_c0 = acc0;
    s_c1 = acc1;
    for (int i = 0; i < STEP_BITS; i++) begin
      if (s_a0[CRC_W-1]) s_c0 = s_c0 ^ s_b;
      if (s_a1[CRC_W-1]) s_c1 = s_c1 ^ s_b;
      s_a0 = s_a0 << 1;
      s_a1 = s_a1 << 1;
      s_b  = s_b[0] ? ((s_b >> 1) ^ poly) : (s_b >> 1);
    end
  end

  assign result        = v0 ^ (full ? (~piece ^ v1) : piece);
  assign stat.len_bit  = len[tbl_idx];
  assign stat.out_busy = out_valid & out_stall;
  assign tbl_wdata     = v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly      <= POLY_RESET;
      merged    <= ALL_ONES;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        poly <= cfg_write_data;
      end
      if (cmd.finish) begin
        merged    <= result;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      len   <= child_length[LEN_BITS-1:0];
      piece <= child_crc;
      full  <= child_is_full;
      v0    <= restart ? ALL_ONES : merged;
      v1    <= ALL_ONES;
    end
    if (cmd.build_init) begin
      v0 <= X8_POWER;
    end
    if (cmd.load_square) begin
      ma0  <= v0;
      ma1  <= v1;
      mb   <= v0;
      acc0 <= '0;
      acc1 <= '0;
    end
    if (cmd.load_item) begin
      ma0  <= v0;
      ma1  <= v1;
      mb   <= tbl_rdata;
      acc0 <= '0;
      acc1 <= '0;
    end
    if (cmd.mul_step) begin
      ma0  <= s_a0;
      ma1  <= s_a1;
      mb   <= s_b;
      acc0 <= s_c0;
      acc1 <= s_c1;
    end
    if (cmd.mul_commit) begin
      v0 <= s_c0;
      v1 <= s_c1;
    end
    if (cmd.finish) begin
      merged_crc <= result;
    end
  end

endmodule

`default_nettype wire

### sv/crc32_child_merger_core.sv
// CRC-32 piece merger top level; depends on crc32cm_pkg, crc32cm_ctrl, crc32cm_datapath, crc32cm_ram.
// Each input transaction walks LEN_BITS = min(MAX_POWER+1, 63) length bits, with a multiply for
// every set bit, before its result is registered.
// Throughput: one transaction at a time; the next is taken the cycle after the result registers.
// Reset (synchronous, rst high) rebuilds the power table with in_stall high; every polynomial
// write starts the same rebuild.
`timescale 1ns / 1ps
`default_nettype none

module crc32_child_merger_core #(
  parameter int MAX_POWER = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration: the reflected generator polynomial.
  input  logic                          cfg_write_enable,
  input  logic [crc32cm_pkg::CRC_W-1:0] cfg_write_data,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          restart,
  input  logic [crc32cm_pkg::LEN_W-1:0] child_length,
  input  logic [crc32cm_pkg::CRC_W-1:0] child_crc,
  input  logic                          child_is_full,
  // Output channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [crc32cm_pkg::CRC_W-1:0] merged_crc
);

  import crc32cm_pkg::*;

  localparam int IDX_W = $clog2(MAX_POWER + 1);

  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] tbl_idx;
  logic [CRC_W-1:0] tbl_wdata;
  logic [CRC_W-1:0] tbl_rdata;

  // The controller walks the length bits from the top one down to bit zero. Every set
  // bit k costs a table read of x^(8*2^k), a load step and the multiply steps; a
  // clear bit costs only a scan step. The multiply unit runs the merged register and an
  // all-ones lane side by side, so the conversion of a full piece CRC is done in the same steps.
  // During the table build the same unit squares each entry to form the next one.
  crc32cm_ctrl #(
    .MAX_POWER (MAX_POWER)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .cfg_write_enable (cfg_write_enable),
    .stat             (stat),
    .cmd              (cmd),
    .tbl_idx          (tbl_idx),
    .in_stall         (in_stall)
  );

  // The datapath holds the polynomial, the merged register and the output register.
  // The output register lets a finished result wait for the receiver while the
  // controller already takes the next input transaction.
  crc32cm_datapath #(
    .MAX_POWER (MAX_POWER)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .tbl_idx          (tbl_idx),
    .tbl_rdata        (tbl_rdata),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .restart          (restart),
    .child_length     (child_length),
    .child_crc        (child_crc),
    .child_is_full    (child_is_full),
    .out_stall        (out_stall),
    .stat             (stat),
    .tbl_wdata        (tbl_wdata),
    .out_valid        (out_valid),
    .merged_crc       (merged_crc)
  );

  // Power table: entry k holds x^(8*2^k) mod P. It is written during the build and
  // read at one address at a time during the length scan; its read data is registered.
  crc32cm_ram #(
    .WIDTH (CRC_W),
    .DEPTH (MAX_POWER + 1)
  ) u_power_table (
    .clk   (clk),
    .we    (cmd.tbl_write),
    .addr  (tbl_idx),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

endmodule

`default_nettype wire

### sv/crc32cm_checker.sv
// Port-level checks for the CRC-32 piece merger, bound to crc32_child_merger_core.
// Depends on crc32cm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module crc32cm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_write_enable,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [crc32cm_pkg::CRC_W-1:0] merged_crc
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(merged_crc))
    else $error("stalled result changed or dropped");

  // One transaction at a time: the block is busy right after it takes one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  // A polynomial write starts a table rebuild, which blocks the input.
  a_rebuild_on_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_write_enable |=> in_stall)
    else $error("input open right after a polynomial write");

  // Leaving reset: table build running and no result pending.
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> in_stall && !out_valid)
    else $error("wrong state after reset");

endmodule

bind crc32_child_merger_core crc32cm_checker u_checker (.*);

`default_nettype wire

### dv/crc32_child_merger_core_tb.sv
// Self-checking testbench for crc32_child_merger_core, the reflected CRC-32 piece merger.
// Depends on crc32cm_pkg and the block's RTL; a scoreboard class predicts every merged CRC.
`timescale 1ns / 1ps

module crc32_child_merger_core_tb;
  import crc32cm_pkg::*;

  localparam int TB_MAX_POWER = 63;
  // Longer than the slowest result takes, so this drains anything still in flight.
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 80;

  // Tracks the merged CRC register and the power table, and queues the merged
  // value expected for each accepted transaction.
  class crc_merge_tracker;
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] merged;
    logic [CRC_W-1:0] powers [0:TB_MAX_POWER];
    logic [CRC_W-1:0] expected_crcs [$];
    int mismatches;

    function new();
      mismatches = 0;
      merged = ALL_ONES;
      set_polynomial(POLY_RESET);
    endfunction

    // Reflected GF(2) product of a and b modulo the current polynomial.
    function logic [CRC_W-1:0] times_mod(logic [CRC_W-1:0] a, logic [CRC_W-1:0] b);
      logic [CRC_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < CRC_W; i++) begin
        if (a[CRC_W-1]) acc ^= b;
        a = a << 1;
        b = b[0] ? ((b >> 1) ^ poly) : (b >> 1);
      end
      return acc;
    endfunction

    // A new polynomial rebuilds the table of x^(8*2^k); the merged register is kept.
    function void set_polynomial(logic [CRC_W-1:0] p);
      poly = p;
      powers[0] = X8_POWER;
      for (int k = 1; k <= TB_MAX_POWER; k++) powers[k] = times_mod(powers[k-1], powers[k-1]);
    endfunction

    // Multiplies v by x^(8*bytes), one table entry per set bit of the length.
    function logic [CRC_W-1:0] skip_bytes(logic [CRC_W-1:0] v, logic [63:0] bytes);
      for (int k = TB_MAX_POWER; k >= 0; k--) begin
        if (bytes[k]) v = times_mod(v, powers[k]);
      end
      return v;
    endfunction

    function void note_piece(bit restart_i, logic [LEN_W-1:0] len_i, logic [CRC_W-1:0] crc_i,
                             bit full_i);
      logic [CRC_W-1:0] piece;
      logic [63:0] bytes;
      bytes = {1'b0, len_i};
      piece = crc_i;
      if (restart_i) merged = ALL_ONES;
      if (full_i) piece = ~crc_i ^ skip_bytes(ALL_ONES, bytes);
      merged = skip_bytes(merged, bytes) ^ piece;
      expected_crcs.push_back(merged);
    endfunction

    function void check_merged(logic [CRC_W-1:0] got);
      logic [CRC_W-1:0] want;
      if (expected_crcs.size() == 0) begin
        $error("merged_crc: no result expected, actual %08h", got);
        mismatches++;
        return;
      end
      want = expected_crcs.pop_front();
      if (got !== want) begin
        $error("merged_crc: expected %08h, actual %08h", want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_crcs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_enable = 1'b0;
  logic [CRC_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic restart = 1'b0;
  logic [LEN_W-1:0] child_length = '0;
  logic [CRC_W-1:0] child_crc = '0;
  logic child_is_full = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CRC_W-1:0] merged_crc;

  crc_merge_tracker board = new();

  // Idling levels in percent, changed per phase by the stimulus.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // The stimulus bumps hold_requests; the receiver serves each with a long hold-off.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  crc32_child_merger_core #(
    .MAX_POWER(TB_MAX_POWER)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .restart(restart),
    .child_length(child_length),
    .child_crc(child_crc),
    .child_is_full(child_is_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .merged_crc(merged_crc)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a counted hold-off that lets the block back up
  // so that its input side has to stall the sender.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Output monitor; values seen here are the ones present before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_merged(merged_crc);
  end

  // Offers one piece and returns at the edge where it was taken. Valid stays high
  // so that the next call can follow without a bubble.
  task automatic send_piece(bit restart_i, logic [LEN_W-1:0] len_i, logic [CRC_W-1:0] crc_i,
                            bit full_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= restart_i;
    child_length <= len_i;
    child_crc <= crc_i;
    child_is_full <= full_i;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_piece(restart_i, len_i, crc_i, full_i);
  endtask

  // Mostly short pieces, some at full length width, a few of length zero.
  task automatic send_random_piece();
    logic [LEN_W-1:0] len;
    logic [CRC_W-1:0] crc;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) len = '0;
    else if (pick < 55) len = LEN_W'($urandom_range(300));
    else len = LEN_W'({$urandom, $urandom});
    crc = $urandom;
    pick = $urandom_range(19);
    if (pick == 0) crc = '0;
    else if (pick == 1) crc = ALL_ONES;
    send_piece($urandom_range(7) == 0, len, crc, 1'($urandom_range(1)));
  endtask

  // Drops valid and waits until every expected merged CRC has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Only called with the block idle; the write starts a table rebuild, during
  // which in_stall holds the next transaction off.
  task automatic write_polynomial(logic [CRC_W-1:0] p);
    repeat (4) @(posedge clk);
    while (in_stall) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= p;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    board.set_polynomial(p);
  endtask

  initial begin : stimulus
    logic [CRC_W-1:0] poly_plan [PHASES];
    poly_plan[0] = POLY_RESET;
    poly_plan[1] = '0;
    poly_plan[2] = ALL_ONES;
    poly_plan[3] = 32'h82f6_3b78;
    poly_plan[4] = $urandom;
    poly_plan[5] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed pieces under the reset polynomial; the block is still rebuilding
    // its table at first, so the first one waits on in_stall.
    send_piece(1'b0, '0, '0, 1'b0);
    send_piece(1'b0, '0, '0, 1'b1);
    send_piece(1'b0, '0, ALL_ONES, 1'b1);
    send_piece(1'b0, 63'd1, ALL_ONES, 1'b0);
    send_piece(1'b1, 63'd1, '0, 1'b1);
    send_piece(1'b0, {LEN_W{1'b1}}, 32'h1234_5678, 1'b1);
    send_piece(1'b1, {LEN_W{1'b1}}, 32'hcbf4_3926, 1'b0);
    send_piece(1'b0, 63'h4000_0000_0000_0000, 32'h8000_0001, 1'b0);
    send_piece(1'b0, 63'h5555_5555_5555_5555, 32'haaaa_aaaa, 1'b1);
    send_piece(1'b0, 63'h2aaa_aaaa_aaaa_aaaa, 32'h5555_5555, 1'b0);
    send_piece(1'b1, '0, ALL_ONES, 1'b0);
    send_piece(1'b0, 63'd9, 32'hcbf4_3926, 1'b1);
    send_piece(1'b0, 63'd256, '0, 1'b0);
    send_piece(1'b1, 63'd4, 32'h0000_0001, 1'b1);
    send_piece(1'b0, 63'h0000_0001_0000_0000, 32'hdead_beef, 1'b0);
    send_piece(1'b1, {LEN_W{1'b1}}, ALL_ONES, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_polynomial(poly_plan[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct = 17;
          recv_stall_pct = 17;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mid-phase, once a long receiver hold-off while the sender keeps
        // offering, and once a full pause of the sender.
        if (n == PHASE_ITEMS / 2 && ph == 1) hold_requests++;
        if (n == PHASE_ITEMS / 2 && ph == 4) wait_drained();
        send_random_piece();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Far above the slowest correct run: about 500 transactions plus stalls, table rebuilds
  // and the hold-off.
  initial begin : watchdog
    #(64'd12_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
